@@ sv/pidinv_pkg.sv @@
package pidinv_pkg;

	localparam int unsigned FRAC_BITS_DEF = 14;
	localparam int unsigned CFG_IDX_W     = 3;

	localparam logic [15:0] SETPOINT_RST = 16'd3000;
	localparam logic [15:0] GAIN_P_RST   = 16'd500;
	localparam logic [15:0] GAIN_I_RST   = 16'd200;
	localparam logic [15:0] GAIN_D_RST   = 16'd200;
	localparam logic [15:0] OUT_MIN_RST  = 16'd0;
	localparam logic [15:0] OUT_MAX_RST  = 16'h1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_GAIN_P   = 3'd1,
		REG_GAIN_I   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_OUT_MIN  = 3'd4,
		REG_OUT_MAX  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] setpoint;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] out_min;
		logic [15:0] out_max;
	} cfg_t;

endpackage

@@ sv/pid_step_inverted_clamp.sv @@
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    measurement[15:0]
// out       out  out_valid / out_stall  drive[15:0]
// cfg       in   cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[15:0]
//
// One request per cycle unless the output stalls. From acceptance to drive:
// input register, then the whole PID step (three 32-bit multiplies, add, shift,
// clamp) into the result register. The integral and drive history update as a
// step leaves the input register. Reset clears the integral and drive history,
// loads the default registers. A stall holds the result and a full input register.
module pid_step_inverted_clamp #(
	parameter int unsigned FRAC_BITS = pidinv_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [15:0]                         measurement,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [15:0]                         drive,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pidinv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                         cfg_data
);
	import pidinv_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [15:0] meas_s1;
	logic        out_valid_q;
	logic [15:0] drive_q;
	logic        advance;
	logic [15:0] drive_next;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_RST;
			cfg_q.gain_p   <= GAIN_P_RST;
			cfg_q.gain_i   <= GAIN_I_RST;
			cfg_q.gain_d   <= GAIN_D_RST;
			cfg_q.out_min  <= OUT_MIN_RST;
			cfg_q.out_max  <= OUT_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SETPOINT: cfg_q.setpoint <= cfg_data;
				REG_GAIN_P:   cfg_q.gain_p   <= cfg_data;
				REG_GAIN_I:   cfg_q.gain_i   <= cfg_data;
				REG_GAIN_D:   cfg_q.gain_d   <= cfg_data;
				REG_OUT_MIN:  cfg_q.out_min  <= cfg_data;
				REG_OUT_MAX:  cfg_q.out_max  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			meas_s1 <= measurement;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_next;
		end
	end

	pidinv_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.measurement (meas_s1),
		.cfg         (cfg_q),
		.drive_next  (drive_next)
	);

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> drive_q <= cfg_q.out_max)
		else $error("drive above out_max");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room downstream");

	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && drive_q == $past(drive_next))
		else $error("step result not captured");

endmodule

@@ sv/pidinv_core.sv @@
module pidinv_core #(
	parameter int unsigned FRAC_BITS = pidinv_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [15:0]        measurement,
	input  pidinv_pkg::cfg_t   cfg,
	output logic [15:0]        drive_next
);
	import pidinv_pkg::*;

	logic [31:0]        integral_q;
	logic [15:0]        drive_now_q;
	logic [15:0]        drive_prev_q;

	logic [31:0]        err;
	logic [31:0]        p_term;
	logic [31:0]        i_prod;
	logic signed [31:0] i_inc;
	logic [31:0]        integral_next;
	logic [31:0]        d_diff;
	logic [31:0]        d_term;
	logic [31:0]        sum;
	logic signed [31:0] shifted;
	logic signed [31:0] lo;
	logic signed [31:0] hi;
	logic signed [31:0] clamp_lo;
	logic signed [31:0] clamped;

	always_comb begin
		err           = {16'd0, measurement} - {16'd0, cfg.setpoint};
		p_term        = err * {16'd0, cfg.gain_p};
		i_prod        = err * {16'd0, cfg.gain_i};
		i_inc         = $signed(i_prod) >>> FRAC_BITS;
		integral_next = integral_q + i_inc;
		d_diff        = {16'd0, drive_now_q} - {16'd0, drive_prev_q};
		d_term        = d_diff * {16'd0, cfg.gain_d};
		sum           = p_term + integral_next + d_term;
		shifted       = $signed(sum) >>> FRAC_BITS;
		lo            = $signed({16'd0, cfg.out_min});
		hi            = $signed({16'd0, cfg.out_max});
		// min first, then max: max wins when the limits cross
		clamp_lo      = (shifted < lo) ? lo : shifted;
		clamped       = (clamp_lo > hi) ? hi : clamp_lo;
		drive_next    = cfg.out_max - clamped[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			drive_now_q  <= '0;
			drive_prev_q <= '0;
		end else if (advance) begin
			integral_q   <= integral_next;
			drive_prev_q <= drive_now_q;
			drive_now_q  <= drive_next;
		end
	end

	a_drive_shift: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> drive_prev_q == $past(drive_now_q) && drive_now_q == $past(drive_next))
		else $error("drive history not shifted on step");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(integral_q) && $stable(drive_now_q))
		else $error("controller state changed without a step");

endmodule
